>>> sv/svgcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgcp_pkg
// Shared types and codes for the color string parser.
// ----------------------------------------------------------------------------
package svgcp_pkg;

    localparam int PhaseW = 4;
    localparam int PosW   = 3;
    localparam int CompW  = 8;
    localparam int CharW  = 8;
    localparam int StatW  = 2;

    localparam logic [PhaseW-1:0] PH_START = 4'd0;
    localparam logic [PhaseW-1:0] PH_HASH  = 4'd1;
    localparam logic [PhaseW-1:0] PH_PFX_G = 4'd2;
    localparam logic [PhaseW-1:0] PH_PFX_B = 4'd3;
    localparam logic [PhaseW-1:0] PH_PFX_P = 4'd4;
    localparam logic [PhaseW-1:0] PH_RED   = 4'd5;
    localparam logic [PhaseW-1:0] PH_GREEN = 4'd6;
    localparam logic [PhaseW-1:0] PH_BLUE  = 4'd7;
    localparam logic [PhaseW-1:0] PH_DONE  = 4'd8;
    localparam logic [PhaseW-1:0] PH_NAMED = 4'd9;

    localparam logic [StatW-1:0] ST_OK      = 2'd0;
    localparam logic [StatW-1:0] ST_BAD_LEN = 2'd1;
    localparam logic [StatW-1:0] ST_NAMED   = 2'd2;
    localparam logic [StatW-1:0] ST_BAD_HEX = 2'd3;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [PosW-1:0]   pos;
        logic [CompW-1:0]  red;
        logic [CompW-1:0]  green;
        logic [CompW-1:0]  blue;
        logic              pct;
        logic              hex_bad;
    } parse_state_t;

    typedef struct packed {
        logic [CompW-1:0] red;
        logic [CompW-1:0] green;
        logic [CompW-1:0] blue;
        logic             pct;
        logic [StatW-1:0] status;
    } parse_result_t;

endpackage

>>> sv/svg_color_string_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svg_color_string_parser
// Streaming parser for #rgb, #rrggbb and rgb(r,g,b) color strings.
// ----------------------------------------------------------------------------
// Takes one character word per cycle while in_stall is low, with last_char
// marking the end of the string, and gives one result word per string: 8-bit
// red, green and blue, percent_mode and parse_status. Each character passes an
// input register and then a combinational state update into the state register;
// a string end also writes its result to the output register, which offers it
// once the last character has left the input register.
// When the output register is full and stalled, characters that do not end a
// string keep flowing; only a string end waits for the output to drain.
// ----------------------------------------------------------------------------
module svg_color_string_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [svgcp_pkg::CharW-1:0]    text_char,
    input  logic                           last_char,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [svgcp_pkg::CompW-1:0]    red_value,
    output logic [svgcp_pkg::CompW-1:0]    green_value,
    output logic [svgcp_pkg::CompW-1:0]    blue_value,
    output logic                           percent_mode,
    output logic [svgcp_pkg::StatW-1:0]    parse_status
);
    import svgcp_pkg::*;

    logic               s1_valid_reg;
    logic [CharW-1:0]   s1_char_reg;
    logic               s1_last_reg;
    parse_state_t       state_reg;
    parse_state_t       state_next;
    parse_result_t      res_next;
    parse_result_t      res_reg;
    logic               out_valid_reg;

    logic out_free;
    logic s1_adv;
    logic in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    svgcp_step u_step (
        .cur  (state_reg),
        .ch   (s1_char_reg),
        .last (s1_last_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '{phase: PH_START, default: '0};
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                state_reg <= state_next;
            if (s1_adv && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= text_char;
            s1_last_reg <= last_char;
        end
        if (s1_adv && s1_last_reg)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign red_value    = res_reg.red;
    assign green_value  = res_reg.green;
    assign blue_value   = res_reg.blue;
    assign percent_mode = res_reg.pct;
    assign parse_status = res_reg.status;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status != ST_OK) |->
        (res_reg.red == '0 && res_reg.green == '0 && res_reg.blue == '0 && !res_reg.pct))
        else $error("error result carries nonzero payload");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("string end advanced into a full output register");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> (state_reg.phase == PH_START && state_reg.pos == '0))
        else $error("parser not back at string start after a result");

    a_pos_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pos != '0) |-> (state_reg.phase == PH_HASH))
        else $error("hex position counter moved outside the hash form");

endmodule

>>> sv/svgcp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svgcp_step
// Per-character state update and end-of-string result formatting.
// ----------------------------------------------------------------------------
module svgcp_step (
    input  svgcp_pkg::parse_state_t        cur,
    input  logic [svgcp_pkg::CharW-1:0]    ch,
    input  logic                           last,
    output svgcp_pkg::parse_state_t        nxt,
    output svgcp_pkg::parse_result_t       res
);
    import svgcp_pkg::*;

    localparam logic [CharW-1:0] C_HASH   = 8'h23;
    localparam logic [CharW-1:0] C_PCT    = 8'h25;
    localparam logic [CharW-1:0] C_LPAREN = 8'h28;
    localparam logic [CharW-1:0] C_RPAREN = 8'h29;
    localparam logic [CharW-1:0] C_COMMA  = 8'h2C;
    localparam logic [CharW-1:0] C_R      = 8'h72;
    localparam logic [CharW-1:0] C_G      = 8'h67;
    localparam logic [CharW-1:0] C_B      = 8'h62;
    localparam logic [CharW-1:0] C_SPACE  = 8'h20;
    localparam logic [CompW-1:0] SAT_MAX  = 8'd255;

    // decimal accumulate with saturation; digit value is the low nibble
    function automatic logic [CompW-1:0] dec_acc(input logic [CompW-1:0] acc,
                                                 input logic [CharW-1:0] c);
        logic [11:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, c[3:0]};
        return (v > 12'd255) ? SAT_MAX : v[CompW-1:0];
    endfunction

    logic       is_dig;
    logic       is_sp;
    logic       hex_ok;
    logic [3:0] nib;
    parse_state_t  upd;

    always_comb
    begin
        is_dig = ch inside {[8'h30:8'h39]};
        is_sp  = ch inside {C_SPACE, [8'h09:8'h0D]};
        hex_ok = 1'b1;
        nib    = 4'd0;
        if (is_dig)
        begin
            nib = ch[3:0];
        end
        else if (ch inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            nib = ch[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        upd = cur;
        case (cur.phase)
            PH_START:
            begin
                if (ch == C_HASH)
                    upd.phase = PH_HASH;
                else if (ch == C_R)
                    upd.phase = PH_PFX_G;
                else
                    upd.phase = PH_NAMED;
            end
            PH_HASH:
            begin
                if (!hex_ok)
                    upd.hex_bad = 1'b1;
                case (cur.pos)
                    3'd0: upd.red   = cur.red   | {nib, 4'd0};
                    3'd1: upd.red   = cur.red   | {4'd0, nib};
                    3'd2: upd.green = cur.green | {nib, 4'd0};
                    3'd3: upd.green = cur.green | {4'd0, nib};
                    3'd4: upd.blue  = cur.blue  | {nib, 4'd0};
                    3'd5: upd.blue  = cur.blue  | {4'd0, nib};
                    default: ;
                endcase
                if (cur.pos != 3'd7)
                    upd.pos = cur.pos + 3'd1;
            end
            PH_PFX_G: upd.phase = (ch == C_G) ? PH_PFX_B : PH_NAMED;
            PH_PFX_B: upd.phase = (ch == C_B) ? PH_PFX_P : PH_NAMED;
            PH_PFX_P: upd.phase = (ch == C_LPAREN) ? PH_RED : PH_NAMED;
            PH_RED:
            begin
                if (!is_sp)
                begin
                    if (is_dig)
                        upd.red = dec_acc(cur.red, ch);
                    else if (ch == C_COMMA)
                        upd.phase = PH_GREEN;
                    else if (ch == C_PCT)
                        upd.pct = 1'b1;
                end
            end
            PH_GREEN:
            begin
                if (!is_sp)
                begin
                    if (is_dig)
                        upd.green = dec_acc(cur.green, ch);
                    else if (ch == C_COMMA)
                        upd.phase = PH_BLUE;
                end
            end
            PH_BLUE:
            begin
                if (!is_sp)
                begin
                    if (is_dig)
                        upd.blue = dec_acc(cur.blue, ch);
                    else if (ch == C_RPAREN)
                        upd.phase = PH_DONE;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res = '0;
        case (upd.phase)
            PH_HASH:
            begin
                if (upd.pos != 3'd3 && upd.pos != 3'd6)
                    res.status = ST_BAD_LEN;
                else if (upd.hex_bad)
                    res.status = ST_BAD_HEX;
                else if (upd.pos == 3'd3)
                begin
                    // short form: nibble doubled
                    res.red   = {upd.red[7:4], upd.red[7:4]};
                    res.green = {upd.red[3:0], upd.red[3:0]};
                    res.blue  = {upd.green[7:4], upd.green[7:4]};
                end
                else
                begin
                    res.red   = upd.red;
                    res.green = upd.green;
                    res.blue  = upd.blue;
                end
            end
            PH_RED, PH_GREEN, PH_BLUE, PH_DONE:
            begin
                res.red   = upd.red;
                res.green = upd.green;
                res.blue  = upd.blue;
                res.pct   = upd.pct;
            end
            default: res.status = ST_NAMED;
        endcase
    end

    always_comb
    begin
        nxt = upd;
        if (last)
        begin
            nxt       = '0;
            nxt.phase = PH_START;
        end
    end

endmodule
